@@ design/gssg_pkg.sv @@
package gssg_pkg;

   localparam logic [6:0] MAX_RANKS = 7'd64;
   localparam logic [2:0] MOD_LAST_SHIFT = 3'd5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MOD,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef enum logic {
      CSR_RANK_SIZE = 1'b0,
      CSR_OWN_RANK  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic mod_step;
      logic setup;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic mod_last;
      logic out_free;
      logic emit_last;
   } status_type;

   // ceil(log2 r), zero below two
   function automatic logic [2:0] count_steps(input logic [6:0] r);
      logic [6:0] t;
      logic [2:0] n;
      t = r - 7'd1;
      n = '0;
      for (int i = 0; i < 7; i++) begin
         if (t[i]) begin
            n = 3'(i + 1);
         end
      end
      if (r < 7'd2) begin
         n = '0;
      end
      return n;
   endfunction

   // (a - b) mod r, for a < r, b < 2r
   function automatic logic [5:0] sub_mod(input logic [5:0] a, input logic [6:0] b,
                                          input logic [6:0] r);
      logic [7:0] bm;
      logic [7:0] v;
      bm = (b >= r) ? {1'b0, b - r} : {1'b0, b};
      v  = {2'b00, a} + {1'b0, r} - bm;
      if (v >= {1'b0, r}) begin
         v = v - {1'b0, r};
      end
      return v[5:0];
   endfunction

endpackage

@@ design/gssg_ctrl.sv @@
module gssg_ctrl
   import gssg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/gssg_datapath.sv @@
module gssg_datapath
   import gssg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data,
   input  logic [5:0] req_step_index,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_step_valid,
   output logic [2:0] rsp_step_count,
   output logic [5:0] rsp_send_to,
   output logic [5:0] rsp_recv_from,
   output logic [5:0] rsp_slice_count,
   output logic [5:0] rsp_tx_slice,
   output logic [5:0] rsp_rx_slice,
   output logic       rsp_last
);

   logic [6:0] rank_size_ff;
   logic [5:0] own_rank_ff;
   logic [6:0] r_eff;
   logic [2:0] n_now;

   logic [5:0] step_ff;
   logic [2:0] n_ff;
   logic       valid_ff;
   logic [5:0] rem_ff;
   logic [2:0] shift_ff;
   logic [5:0] snd_ff;
   logic [5:0] rcv_ff;
   logic [5:0] nsl_ff;
   logic [6:0] bm_ff;
   logic [5:0] tx_ff;
   logic [5:0] rx_ff;
   logic [5:0] cnt_ff;

   logic [12:0] cand;
   logic [2:0]  k;
   logic [6:0]  d;
   logic [7:0]  delta;
   logic [7:0]  sum;
   logic [7:0]  nsl_wide;
   logic [6:0]  snd_sum;
   logic [5:0]  snd_in;
   logic [6:0]  bm_in;

   logic       rsp_valid_ff;
   logic       rsp_step_valid_ff;
   logic [2:0] rsp_step_count_ff;
   logic [5:0] rsp_send_to_ff;
   logic [5:0] rsp_recv_from_ff;
   logic [5:0] rsp_slice_count_ff;
   logic [5:0] rsp_tx_slice_ff;
   logic [5:0] rsp_rx_slice_ff;
   logic       rsp_last_ff;

   assign r_eff = (rank_size_ff > MAX_RANKS) ? MAX_RANKS : rank_size_ff;
   assign n_now = count_steps(r_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_size_ff <= 7'd2;
         own_rank_ff  <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_RANK_SIZE: rank_size_ff <= csr_write_data;
            CSR_OWN_RANK:  own_rank_ff  <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   // reduction of own rank, one shifted compare per cycle
   assign cand = {6'b0, r_eff} << shift_ff;

   // step geometry
   assign k        = n_ff - step_ff[2:0];
   assign d        = 7'd1 << (k - 3'd1);
   assign delta    = {d, 1'b0};
   assign sum      = {1'b0, r_eff} - 8'd1 + {1'b0, d};
   assign nsl_wide = sum >> k;
   assign snd_sum  = {1'b0, rem_ff} + d;
   assign snd_in   = (snd_sum >= r_eff) ? 6'(snd_sum - r_eff) : snd_sum[5:0];
   assign bm_in    = (delta >= {1'b0, r_eff}) ? 7'(delta - {1'b0, r_eff}) : delta[6:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         step_ff  <= req_step_index;
         n_ff     <= n_now;
         valid_ff <= ({3'b000, n_now} > req_step_index);
         rem_ff   <= own_rank_ff;
         shift_ff <= MOD_LAST_SHIFT;
      end
      if (cmd.mod_step) begin
         if ({7'b0, rem_ff} >= cand) begin
            rem_ff <= rem_ff - cand[5:0];
         end
         shift_ff <= shift_ff - 3'd1;
      end
      if (cmd.setup) begin
         snd_ff <= snd_in;
         rcv_ff <= sub_mod(rem_ff, d, r_eff);
         nsl_ff <= nsl_wide[5:0];
         bm_ff  <= bm_in;
         tx_ff  <= rem_ff;
         rx_ff  <= sub_mod(rem_ff, d, r_eff);
         cnt_ff <= '0;
      end
      if (cmd.emit) begin
         tx_ff  <= sub_mod(tx_ff, bm_ff, r_eff);
         rx_ff  <= sub_mod(rx_ff, bm_ff, r_eff);
         cnt_ff <= cnt_ff + 6'd1;
      end
   end

   assign status.mod_last  = (shift_ff == 3'd0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.emit_last = !valid_ff || (cnt_ff + 6'd1 == nsl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_step_valid_ff  <= valid_ff;
         rsp_step_count_ff  <= n_ff;
         rsp_send_to_ff     <= valid_ff ? snd_ff : '0;
         rsp_recv_from_ff   <= valid_ff ? rcv_ff : '0;
         rsp_slice_count_ff <= valid_ff ? nsl_ff : '0;
         rsp_tx_slice_ff    <= valid_ff ? tx_ff : '0;
         rsp_rx_slice_ff    <= valid_ff ? rx_ff : '0;
         rsp_last_ff        <= status.emit_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_valid  = rsp_step_valid_ff;
   assign rsp_step_count  = rsp_step_count_ff;
   assign rsp_send_to     = rsp_send_to_ff;
   assign rsp_recv_from   = rsp_recv_from_ff;
   assign rsp_slice_count = rsp_slice_count_ff;
   assign rsp_tx_slice    = rsp_tx_slice_ff;
   assign rsp_rx_slice    = rsp_rx_slice_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ design/gather_step_schedule_generator.sv @@
// The first result is registered after the request transaction, once the own-rank
// reduction, the setup step and the load into the output register are done.
// A new request is taken only after the S slices of the step (1 to 32) are out,
// counted by the single shared emit counter; results go one per cycle unless stalled.
// Reset: synchronous, active high; clears control, rank_size = 2, own_rank = 0.
module gather_step_schedule_generator
   import gssg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [5:0] req_step_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_step_valid,
   output logic [2:0] rsp_step_count,
   output logic [5:0] rsp_send_to,
   output logic [5:0] rsp_recv_from,
   output logic [5:0] rsp_slice_count,
   output logic [5:0] rsp_tx_slice,
   output logic [5:0] rsp_rx_slice,
   output logic       rsp_last
);

   cmd_type    cmd;
   status_type status;

   gssg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gssg_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_step_index  (req_step_index),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_step_valid  (rsp_step_valid),
      .rsp_step_count  (rsp_step_count),
      .rsp_send_to     (rsp_send_to),
      .rsp_recv_from   (rsp_recv_from),
      .rsp_slice_count (rsp_slice_count),
      .rsp_tx_slice    (rsp_tx_slice),
      .rsp_rx_slice    (rsp_rx_slice),
      .rsp_last        (rsp_last)
   );

endmodule

@@ design/gssg_checker.sv @@
module gssg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_step_valid,
   input logic [2:0] rsp_step_count,
   input logic [5:0] rsp_send_to,
   input logic [5:0] rsp_recv_from,
   input logic [5:0] rsp_slice_count,
   input logic [5:0] rsp_tx_slice,
   input logic [5:0] rsp_rx_slice,
   input logic       rsp_last
);

   // stalled response transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_slice) && $stable(rsp_last))
      else $error("stalled response changed");

   // one request at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // out-of-range step gives a single zeroed result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_step_valid |-> rsp_last && rsp_slice_count == 6'd0 &&
         rsp_send_to == 6'd0 && rsp_recv_from == 6'd0 && rsp_rx_slice == 6'd0)
      else $error("bad invalid-step result");

   // a valid step has slices and a nonzero step count
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_valid |-> rsp_slice_count != 6'd0 &&
         rsp_slice_count <= 6'd32 && rsp_step_count != 3'd0)
      else $error("bad valid-step result");

endmodule

bind gather_step_schedule_generator gssg_checker u_gssg_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_step_valid  (rsp_step_valid),
   .rsp_step_count  (rsp_step_count),
   .rsp_send_to     (rsp_send_to),
   .rsp_recv_from   (rsp_recv_from),
   .rsp_slice_count (rsp_slice_count),
   .rsp_tx_slice    (rsp_tx_slice),
   .rsp_rx_slice    (rsp_rx_slice),
   .rsp_last        (rsp_last)
);

@@ tb/gather_step_schedule_generator_tb.sv @@
`timescale 1ns / 1ps

module gather_step_schedule_generator_tb
   import gssg_pkg::*;
();

   typedef struct packed {
      logic       step_valid;
      logic [2:0] step_count;
      logic [5:0] send_to;
      logic [5:0] recv_from;
      logic [5:0] slice_count;
      logic [5:0] tx_slice;
      logic [5:0] rx_slice;
      logic       last;
   } slice_rec_type;

   class slice_schedule_model;
      logic [6:0] rank_size;
      logic [5:0] own_rank;
      slice_rec_type expected_slices[$];
      int unsigned mismatches;
      int unsigned slices_checked;

      function new();
         rank_size = 7'd2;
         own_rank = 6'd0;
         mismatches = 0;
         slices_checked = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [6:0] value);
         if (idx == CSR_RANK_SIZE) begin
            rank_size = value;
         end else begin
            own_rank = value[5:0];
         end
      endfunction

      function int group_size();
         return (rank_size > 7'd64) ? 64 : int'(rank_size);
      endfunction

      function int step_total();
         int r;
         int n;
         r = group_size();
         n = 0;
         if (r >= 2) begin
            for (int t = r - 1; t != 0; t = t >> 1) n++;
         end
         return n;
      endfunction

      function void add_expected(slice_rec_type rec);
         expected_slices[expected_slices.size()] = rec;
      endfunction

      function void note_step(logic [5:0] step);
         int r, n, s, me, pair_gap, stride, nsl, snd, rcv, tx, rx;
         slice_rec_type rec;
         r = group_size();
         n = step_total();
         s = int'(step);
         rec = '0;
         rec.step_count = 3'(n);
         if (s >= n) begin
            rec.last = 1'b1;
            add_expected(rec);
            return;
         end
         me = int'(own_rank) % r;
         pair_gap = 1 << (n - 1 - s);
         stride = 2 * pair_gap;
         nsl = (r - 1 + pair_gap) / stride;
         snd = (me + pair_gap) % r;
         rcv = (me + r - pair_gap) % r;
         tx = me;
         rx = rcv;
         rec.step_valid = 1'b1;
         rec.send_to = 6'(snd);
         rec.recv_from = 6'(rcv);
         rec.slice_count = 6'(nsl);
         for (int k = 0; k < nsl; k++) begin
            rec.tx_slice = 6'(tx);
            rec.rx_slice = 6'(rx);
            rec.last = (k == nsl - 1);
            add_expected(rec);
            tx = (tx + 2 * r - stride) % r;
            rx = (rx + 2 * r - stride) % r;
         end
      endfunction

      function void check_slice(slice_rec_type got);
         slice_rec_type want;
         if (expected_slices.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] unexpected slice transaction: %p", $realtime, got);
            end
            return;
         end
         want = expected_slices.pop_front();
         slices_checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("[%0t] slice mismatch", $realtime);
               $display("   expected %p", want);
               $display("   actual   %p", got);
            end
         end
      endfunction

      function int pending();
         return expected_slices.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic       csr_index;
   logic [6:0] csr_write_data;
   logic       req_valid;
   logic       req_ready;
   logic [5:0] req_step_index;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_step_valid;
   logic [2:0] rsp_step_count;
   logic [5:0] rsp_send_to;
   logic [5:0] rsp_recv_from;
   logic [5:0] rsp_slice_count;
   logic [5:0] rsp_tx_slice;
   logic [5:0] rsp_rx_slice;
   logic       rsp_last;

   slice_schedule_model schedule;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned steps_sent = 0;
   int unsigned groups_set = 0;

   gather_step_schedule_generator u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_step_index (req_step_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_step_valid (rsp_step_valid),
      .rsp_step_count (rsp_step_count),
      .rsp_send_to    (rsp_send_to),
      .rsp_recv_from  (rsp_recv_from),
      .rsp_slice_count(rsp_slice_count),
      .rsp_tx_slice   (rsp_tx_slice),
      .rsp_rx_slice   (rsp_rx_slice),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         schedule.check_slice({rsp_step_valid, rsp_step_count, rsp_send_to, rsp_recv_from,
                               rsp_slice_count, rsp_tx_slice, rsp_rx_slice, rsp_last});
      end
   end

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct <= 0;
            stall_pct <= 0;
         end
         1: begin
            send_idle_pct <= 59;
            stall_pct <= 0;
         end
         2: begin
            send_idle_pct <= 0;
            stall_pct <= 59;
         end
         default: begin
            send_idle_pct <= 21;
            stall_pct <= 21;
         end
      endcase
   endtask

   // valid stays high between back-to-back transactions
   task automatic send_step(logic [5:0] step);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_step_index <= step;
      do @(posedge clock); while (!req_ready);
      schedule.note_step(step);
      steps_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (schedule.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type idx, logic [6:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      schedule.write_reg(idx, value);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_group(logic [6:0] size, logic [6:0] own);
      drain();
      csr_write(CSR_RANK_SIZE, size);
      csr_write(CSR_OWN_RANK, own);
      groups_set++;
   endtask

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int n;
      int r;
      int cnt;
      logic [6:0] size;
      logic [6:0] own;

      schedule = new();
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_RANK_SIZE;
      csr_write_data <= '0;
      req_valid <= 1'b0;
      req_step_index <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset group, full-size group, degenerate and saturated sizes
      send_step(6'd0);
      send_step(6'd1);
      send_step(6'd63);
      set_group(7'd64, 7'd0);
      for (int s = 0; s <= 6; s++) send_step(6'(s));
      set_group(7'd64, 7'd63);
      send_step(6'd0);
      send_step(6'd5);
      set_group(7'd0, 7'd0);
      send_step(6'd0);
      set_group(7'd1, 7'd0);
      send_step(6'd0);
      set_group(7'd127, 7'd50);
      send_step(6'd0);
      send_step(6'd6);
      set_group(7'd3, 7'h45);
      send_step(6'd0);
      send_step(6'd1);
      set_group(7'd33, 7'd32);
      send_step(6'd0);
      send_step(6'd5);

      for (int phase = 0; steps_sent < 125; phase++) begin
         set_idling(phase % 4);
         case ($urandom_range(7))
            0: size = 7'($urandom_range(1));
            1: size = 7'($urandom_range(127, 65));
            2: size = 7'd64;
            3: size = 7'd2;
            default: size = 7'($urandom_range(64, 2));
         endcase
         r = (size > 7'd64) ? 64 : int'(size);
         if (r >= 2 && $urandom_range(99) < 70) begin
            own = {1'($urandom_range(1)), 6'($urandom_range(r - 1))};
         end else begin
            own = 7'($urandom_range(127));
         end
         set_group(size, own);
         n = schedule.step_total();
         cnt = $urandom_range(14, 6);
         for (int i = 0; i < cnt; i++) begin
            if (i == cnt / 2 && $urandom_range(3) == 0) begin
               drain();
            end
            if (n > 0 && $urandom_range(99) < 85) begin
               send_step(6'($urandom_range(n - 1)));
            end else begin
               send_step(6'($urandom_range(63)));
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d step transactions over %0d group settings; %0d slices checked.",
               steps_sent, groups_set, schedule.slices_checked);
      $display("Covered sizes 0 to 127 incl. saturation, wrapped own ranks, invalid steps.");
      if (schedule.mismatches == 0 && schedule.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/gssg_pkg.sv
design/gssg_ctrl.sv
design/gssg_datapath.sv
design/gather_step_schedule_generator.sv
design/gssg_checker.sv
tb/gather_step_schedule_generator_tb.sv
